[src/icnt_pkg.sv]
// Shared constants, types and helpers for the inversion counter.
package icnt_pkg;

    localparam int MAX_ELEMENTS = 256;
    localparam int VALUE_BITS   = 32;
    localparam int INPUT_BITS   = 32;
    localparam int ADDR_BITS    = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int COUNT_BITS   = $clog2(MAX_ELEMENTS + 1);
    localparam int TOTAL_BITS   = 15;

    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] HELD_MAX  = COUNT_BITS'(MAX_ELEMENTS);

    typedef logic signed [VALUE_BITS-1:0] icnt_value_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // take the input item
        logic read;     // issue a store read at the scan index
        logic store;    // write the element, count it
        logic publish;  // move the total to the output, clear the sequence
    } icnt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;      // no element held
        logic full;       // store at capacity
        logic scan_done;  // read issued for the last held element
        logic last;       // current item ends the sequence
        logic out_busy;   // output register holds an item not taken this cycle
    } icnt_status_t;

    // Sign-extend the input, then reduce to VALUE_BITS and read it as signed.
    function automatic icnt_value_t to_element(input logic [INPUT_BITS-1:0] raw);
        logic [2*64-1:0] wide;
        wide = {{(2*64-INPUT_BITS){raw[INPUT_BITS-1]}}, raw};
        return icnt_value_t'(wide[VALUE_BITS-1:0]);
    endfunction

endpackage

[src/icnt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module icnt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                     aclk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/icnt_datapath.sv]
// Datapath: element store, scan compare, running total and output register.
module icnt_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [icnt_pkg::INPUT_BITS-1:0]    s_element_value,
    input  logic                               s_last_element,
    input  icnt_pkg::icnt_cmd_t                cmd,
    output icnt_pkg::icnt_status_t             status,
    output logic [icnt_pkg::TOTAL_BITS-1:0]    m_inversion_total,
    output logic                               m_capacity_exceeded,
    output logic                               m_valid,
    input  logic                               m_ready
);
    import icnt_pkg::*;

    icnt_value_t             elem_reg;
    logic                    last_reg;
    logic [ADDR_BITS-1:0]    idx_reg, idx_next;
    logic [COUNT_BITS-1:0]   held_reg, held_next;
    logic [TOTAL_BITS-1:0]   total_reg, total_next;
    logic                    ovf_reg, ovf_next;
    logic                    rd_pend_reg;
    logic                    m_valid_reg, m_valid_next;
    logic [TOTAL_BITS-1:0]   out_total_reg;
    logic                    out_ovf_reg;
    logic [VALUE_BITS-1:0]   rd_data;
    logic                    greater;

    icnt_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (cmd.store),
        .wr_addr (held_reg[ADDR_BITS-1:0]),
        .wr_data (elem_reg),
        .rd_en   (cmd.read),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign greater = rd_pend_reg && ($signed(rd_data) > elem_reg);

    always_comb begin
        idx_next     = idx_reg;
        held_next    = held_reg;
        total_next   = total_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (cmd.load) begin
            idx_next = '0;
            if (held_reg == HELD_MAX) begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.read) begin
            idx_next = idx_reg + ADDR_BITS'(1);
        end
        // saturating count of held elements above the new one
        if (greater && total_reg != TOTAL_MAX) begin
            total_next = total_reg + TOTAL_BITS'(1);
        end
        if (cmd.store) begin
            held_next = held_reg + COUNT_BITS'(1);
        end
        if (cmd.publish) begin
            held_next    = '0;
            total_next   = '0;
            ovf_next     = 1'b0;
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg    <= '0;
            total_reg   <= '0;
            ovf_reg     <= 1'b0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            held_reg    <= held_next;
            total_reg   <= total_next;
            ovf_reg     <= ovf_next;
            rd_pend_reg <= cmd.read;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (cmd.load) begin
            elem_reg <= to_element(s_element_value);
            last_reg <= s_last_element;
        end
        if (cmd.publish) begin
            out_total_reg <= total_reg;
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign status.empty     = (held_reg == '0);
    assign status.full      = (held_reg == HELD_MAX);
    assign status.scan_done = ((COUNT_BITS'(idx_reg) + COUNT_BITS'(1)) == held_reg);
    assign status.last      = last_reg;
    assign status.out_busy  = m_valid_reg && !m_ready;

    assign m_inversion_total   = out_total_reg;
    assign m_capacity_exceeded = out_ovf_reg;
    assign m_valid             = m_valid_reg;

endmodule

[src/icnt_ctrl.sv]
// Controller: sequences accept, scan, store and publish for each item.
module icnt_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_last_element,
    output logic                   s_ready,
    output icnt_pkg::icnt_cmd_t    cmd,
    input  icnt_pkg::icnt_status_t status
);
    import icnt_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_STORE  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (status.full) begin
                        // drop the item; a dropped last item still ends the sequence
                        state_next = s_last_element ? ST_FINISH : ST_IDLE;
                    end else if (status.empty) begin
                        state_next = ST_STORE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmd.read = 1'b1;
                if (status.scan_done) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                cmd.store  = 1'b1;
                state_next = status.last ? ST_FINISH : ST_IDLE;
            end
            ST_FINISH: begin
                if (!status.out_busy) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[src/inversion_counter.sv]
// Top level of the inversion counter: controller, datapath and checks.
//
//  channel | direction | ports                                   | moves
//  s_      | in        | s_valid s_ready s_element_value s_last_element | one element
//  m_      | out       | m_valid m_ready m_inversion_total m_capacity_exceeded | one result
//
// An element accepted while elements are held passes accept, one read of the store
// RAM per held element into one comparator, and write-back; a dropped element (store
// full) is only accepted. The last element of a sequence adds a publish step.
// Reset (aresetn low, synchronous) empties the sequence and the output register.
// A result still waiting on m_ready holds a later sequence end in its publish
// cycle, and s_ready stays low until the output register drains.
module inversion_counter (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [icnt_pkg::INPUT_BITS-1:0] s_element_value,
    input  logic                            s_last_element,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [icnt_pkg::TOTAL_BITS-1:0] m_inversion_total,
    output logic                            m_capacity_exceeded
);
    import icnt_pkg::*;

    icnt_cmd_t    cmd;
    icnt_status_t status;

    // Sequence the work for each item.
    icnt_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_last_element (s_last_element),
        .s_ready        (s_ready),
        .cmd            (cmd),
        .status         (status)
    );

    // Hold the elements, compare and count, and register the result.
    icnt_datapath u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_element_value     (s_element_value),
        .s_last_element      (s_last_element),
        .cmd                 (cmd),
        .status              (status),
        .m_inversion_total   (m_inversion_total),
        .m_capacity_exceeded (m_capacity_exceeded),
        .m_valid             (m_valid),
        .m_ready             (m_ready)
    );

    // An item that is kept (store not full) moves the controller out of the idle state, so s_ready drops.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !status.full) |=> !s_ready)
        else $error("input accepted on consecutive cycles");

    // Publishing a total always presents an item on the result channel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |=> m_valid)
        else $error("published result not presented");

    // Never write the store beyond its capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.store |-> !status.full)
        else $error("store write with store full");

    // Never publish over a result that is still waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |-> !(m_valid && !m_ready))
        else $error("result overwritten before it was taken");

endmodule
